[hdl/tcp_handshake_connection_tracker_unit_defines.svh]
// Assertion macros for the checker file.
`ifndef TCP_HANDSHAKE_CONNECTION_TRACKER_UNIT_DEFINES_SVH
`define TCP_HANDSHAKE_CONNECTION_TRACKER_UNIT_DEFINES_SVH

// Check in the same cycle, sampled on clk, off while rst is high.
`define THCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check in the following cycle.
`define THCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/thct_pkg.sv]
package thct_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int LANES = 8;
  localparam int LANE_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int IN_W = 136;
  localparam int OUT_W = 112;
  localparam int SLOT_W = 6;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_CREATED = 2'd1,
    ST_ESTABLISHED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OUT_SYNACK = 2'd0,
    OUT_ESTAB = 2'd1,
    OUT_UNEXPECTED = 2'd2,
    OUT_FULL = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    K_HIT,
    K_CLAIM,
    K_FULL
  } kind_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_WAIT,
    F_SCAN,
    F_DRAIN,
    F_PUSH
  } fstate_t;

  typedef struct packed {
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] our_port;
    status_t status;
    logic [31:0] our_seq;
    logic [31:0] ack;
  } entry_t;

  // lowest field last
  typedef struct packed {
    logic [3:0] pad;
    logic [31:0] fresh_isn;
    logic flag_fin;
    logic flag_psh;
    logic flag_ack;
    logic flag_syn;
    logic [31:0] remote_seq;
    logic [15:0] local_port;
    logic [15:0] peer_port;
    logic [31:0] peer_ip;
  } item_t;

  typedef struct packed {
    logic [4:0] pad;
    logic [31:0] reply_ack_seq;
    logic [31:0] reply_seq;
    logic [15:0] reply_dst_port;
    logic [15:0] reply_src_port;
    logic reply_psh;
    logic reply_syn;
    logic reply_valid;
    logic [SLOT_W-1:0] slot;
    outcome_t outcome;
  } result_t;

  typedef struct packed {
    kind_t kind;
    entry_t entry;
    item_t item;
  } rec_t;

endpackage

[hdl/thct_table.sv]
module thct_table #(
  parameter int TABLE_ENTRIES = thct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  output logic clearing,
  input  logic [((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES > 1 ?
                 $clog2((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES) : 1) - 1:0]
                 rd_row,
  output thct_pkg::entry_t rd_data [thct_pkg::LANES],
  input  logic wr_en,
  input  logic [((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES > 1 ?
                 $clog2((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES) : 1) +
                 thct_pkg::LANE_W - 1:0] wr_idx,
  input  thct_pkg::entry_t wr_entry
);
  import thct_pkg::*;

  localparam int ROWS = (TABLE_ENTRIES + LANES - 1) / LANES;
  localparam int ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int IW = ROW_W + LANE_W;

  entry_t mem [LANES][ROWS];
  logic [ROW_W-1:0] clr_row;
  logic [ROW_W-1:0] wr_row;
  logic [LANE_W-1:0] wr_lane;

  assign wr_row = wr_idx[IW-1:LANE_W];
  assign wr_lane = wr_idx[LANE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (clearing) begin
        mem[l][clr_row] <= '0;
      end else if (wr_en && wr_lane == LANE_W'(l)) begin
        mem[l][wr_row] <= wr_entry;
      end
      rd_data[l] <= mem[l][rd_row];
    end
  end

endmodule

[hdl/thct_front.sv]
module thct_front #(
  parameter int TABLE_ENTRIES = thct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [thct_pkg::IN_W-1:0] s_tdata,
  input  logic clearing,
  output logic [((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES > 1 ?
                 $clog2((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES) : 1) - 1:0]
                 rd_row,
  input  thct_pkg::entry_t rd_data [thct_pkg::LANES],
  input  logic q_empty,
  input  logic q_full,
  output logic q_push,
  output thct_pkg::rec_t q_rec,
  output logic [((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES > 1 ?
                 $clog2((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES) : 1) +
                 thct_pkg::LANE_W - 1:0] q_idx
);
  import thct_pkg::*;

  localparam int ROWS = (TABLE_ENTRIES + LANES - 1) / LANES;
  localparam int ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int IW = ROW_W + LANE_W;
  localparam logic [IW:0] N_LIM = (IW + 1)'(TABLE_ENTRIES);

  fstate_t state, state_next;
  item_t item;
  logic [ROW_W-1:0] scan_row;
  logic eval_valid;
  logic [ROW_W-1:0] eval_row;
  logic hit_found, free_found;
  logic [IW-1:0] hit_idx, free_idx;
  entry_t hit_entry, free_entry;
  logic [LANES-1:0] hitv, freev;
  logic row_hit, row_free;
  logic [LANE_W-1:0] hit_lane, free_lane;

  assign s_tready = (state == F_IDLE) && !clearing;
  assign rd_row = scan_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_push = 1'b0;
    case (state)
      F_IDLE: begin
        if (s_tvalid && s_tready) begin
          state_next = F_WAIT;
        end
      end
      F_WAIT: begin
        if (q_empty) begin
          state_next = F_SCAN;
        end
      end
      F_SCAN: begin
        if (scan_row == ROW_W'(ROWS - 1)) begin
          state_next = F_DRAIN;
        end
      end
      F_DRAIN: begin
        state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_comb begin
    row_hit = 1'b0;
    row_free = 1'b0;
    hit_lane = '0;
    free_lane = '0;
    for (int l = 0; l < LANES; l++) begin
      hitv[l] = ({1'b0, eval_row, LANE_W'(l)} < N_LIM) &&
                rd_data[l].status != ST_NONE &&
                rd_data[l].peer_ip == item.peer_ip &&
                (rd_data[l].peer_port == item.peer_port ||
                 rd_data[l].our_port == item.peer_port);
      freev[l] = ({1'b0, eval_row, LANE_W'(l)} < N_LIM) &&
                 rd_data[l].status == ST_NONE &&
                 rd_data[l].peer_ip == 32'd0 &&
                 rd_data[l].peer_port == 16'd0;
    end
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hitv[l]) begin
        row_hit = 1'b1;
        hit_lane = LANE_W'(l);
      end
      if (freev[l]) begin
        row_free = 1'b1;
        free_lane = LANE_W'(l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_valid <= 1'b0;
    end else begin
      eval_valid <= (state == F_SCAN);
    end
    eval_row <= scan_row;
    if (s_tvalid && s_tready) begin
      item <= item_t'(s_tdata);
    end
    if (state == F_WAIT) begin
      scan_row <= '0;
      hit_found <= 1'b0;
      free_found <= 1'b0;
    end else if (state == F_SCAN) begin
      scan_row <= scan_row + 1'b1;
    end
    if (eval_valid) begin
      if (!hit_found && row_hit) begin
        hit_found <= 1'b1;
        hit_idx <= {eval_row, hit_lane};
        hit_entry <= rd_data[hit_lane];
      end
      if (!free_found && row_free) begin
        free_found <= 1'b1;
        free_idx <= {eval_row, free_lane};
        free_entry <= rd_data[free_lane];
      end
    end
  end

  always_comb begin
    q_rec.item = item;
    if (hit_found) begin
      q_rec.kind = K_HIT;
      q_rec.entry = hit_entry;
      q_idx = hit_idx;
    end else if (free_found) begin
      q_rec.kind = K_CLAIM;
      q_rec.entry = free_entry;
      q_idx = free_idx;
    end else begin
      q_rec.kind = K_FULL;
      q_rec.entry = hit_entry;
      q_idx = hit_idx;
    end
  end

endmodule

[hdl/thct_queue.sv]
module thct_queue #(
  parameter int TABLE_ENTRIES = thct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  thct_pkg::rec_t push_rec,
  input  logic [((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES > 1 ?
                 $clog2((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES) : 1) +
                 thct_pkg::LANE_W - 1:0] push_idx,
  input  logic pop,
  output logic empty,
  output logic full,
  output thct_pkg::rec_t head_rec,
  output logic [((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES > 1 ?
                 $clog2((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES) : 1) +
                 thct_pkg::LANE_W - 1:0] head_idx
);
  import thct_pkg::*;

  localparam int ROWS = (TABLE_ENTRIES + LANES - 1) / LANES;
  localparam int ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int IW = ROW_W + LANE_W;

  rec_t rec_mem [QUEUE_DEPTH];
  logic [IW-1:0] idx_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QPTR_W:0] cnt;

  assign empty = (cnt == '0);
  assign full = (cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_rec = rec_mem[rp];
  assign head_idx = idx_mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) begin
        wp <= wp + 1'b1;
      end
      if (pop && !empty) begin
        rp <= rp + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        cnt <= cnt + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      rec_mem[wp] <= push_rec;
      idx_mem[wp] <= push_idx;
    end
  end

endmodule

[hdl/thct_back.sv]
module thct_back #(
  parameter int TABLE_ENTRIES = thct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  output logic q_pop,
  input  thct_pkg::rec_t head_rec,
  input  logic [((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES > 1 ?
                 $clog2((TABLE_ENTRIES + thct_pkg::LANES - 1) / thct_pkg::LANES) : 1) +
                 thct_pkg::LANE_W - 1:0] head_idx,
  output logic wr_en,
  output thct_pkg::entry_t wr_entry,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [thct_pkg::OUT_W-1:0] m_tdata
);
  import thct_pkg::*;

  entry_t cur;
  result_t res, res_q;
  logic bare_syn, bare_ack, created, write_entry;

  assign q_pop = !q_empty && (!m_tvalid || m_tready);
  assign wr_en = q_pop && write_entry;
  assign m_tdata = res_q;

  assign bare_syn = head_rec.item.flag_syn && !head_rec.item.flag_ack &&
                    !head_rec.item.flag_psh && !head_rec.item.flag_fin;
  assign bare_ack = !head_rec.item.flag_syn && head_rec.item.flag_ack &&
                    !head_rec.item.flag_psh && !head_rec.item.flag_fin;

  always_comb begin
    cur = head_rec.entry;
    if (head_rec.kind == K_CLAIM) begin
      cur.peer_ip = head_rec.item.peer_ip;
      cur.peer_port = head_rec.item.peer_port;
      cur.status = ST_CREATED;
      cur.our_seq = head_rec.item.remote_seq;
    end
    created = (cur.status == ST_CREATED);
    wr_entry = cur;
    write_entry = 1'b0;
    res = '0;
    case (head_rec.kind)
      K_HIT, K_CLAIM: begin
        write_entry = (head_rec.kind == K_CLAIM);
        res.slot = SLOT_W'(head_idx);
        if (created && bare_syn) begin
          wr_entry.our_seq = head_rec.item.fresh_isn;
          wr_entry.ack = head_rec.item.remote_seq + 32'd1;
          wr_entry.our_port = head_rec.item.local_port;
          write_entry = 1'b1;
          res.outcome = OUT_SYNACK;
          res.reply_valid = 1'b1;
          res.reply_syn = 1'b1;
          res.reply_src_port = head_rec.item.local_port;
          res.reply_dst_port = head_rec.item.peer_port;
          res.reply_seq = head_rec.item.fresh_isn;
          res.reply_ack_seq = head_rec.item.remote_seq + 32'd1;
        end else if (created && bare_ack) begin
          wr_entry.status = ST_ESTABLISHED;
          wr_entry.our_seq = cur.our_seq + 32'd1;
          write_entry = 1'b1;
          res.outcome = OUT_ESTAB;
          res.reply_valid = 1'b1;
          res.reply_psh = 1'b1;
          res.reply_src_port = cur.our_port;
          res.reply_dst_port = cur.peer_port;
          res.reply_seq = cur.our_seq + 32'd1;
          res.reply_ack_seq = cur.ack;
        end else begin
          res.outcome = OUT_UNEXPECTED;
        end
      end
      default: begin
        res.outcome = OUT_FULL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (q_pop) begin
      res_q <= res;
    end
  end

endmodule

[hdl/tcp_handshake_connection_tracker_unit.sv]
// The front takes a new segment only after the last one has been scanned and
// pushed to the queue; its scan reads one row of eight table entries per cycle.
// Reset: synchronous; the table is then swept clear, one row per cycle, with
// s_tready held low.
module tcp_handshake_connection_tracker_unit #(
  parameter int TABLE_ENTRIES = thct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // peer_ip, peer_port, local_port, remote_seq, flag_syn, flag_ack, flag_psh,
  // flag_fin, fresh_isn, zero pad
  input  logic [thct_pkg::IN_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // outcome, slot, reply_valid, reply_syn, reply_psh, reply_src_port,
  // reply_dst_port, reply_seq, reply_ack_seq, zero pad
  output logic [thct_pkg::OUT_W-1:0] m_tdata
);
  import thct_pkg::*;

  localparam int ROWS = (TABLE_ENTRIES + LANES - 1) / LANES;
  localparam int ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int IW = ROW_W + LANE_W;

  logic clearing;
  logic [ROW_W-1:0] rd_row;
  entry_t rd_data [LANES];
  logic wr_en;
  entry_t wr_entry;
  logic q_push, q_pop, q_empty, q_full;
  rec_t push_rec, head_rec;
  logic [IW-1:0] push_idx, head_idx;

  thct_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk(clk),
    .rst(rst),
    .clearing(clearing),
    .rd_row(rd_row),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_idx(head_idx),
    .wr_entry(wr_entry)
  );

  thct_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .clearing(clearing),
    .rd_row(rd_row),
    .rd_data(rd_data),
    .q_empty(q_empty),
    .q_full(q_full),
    .q_push(q_push),
    .q_rec(push_rec),
    .q_idx(push_idx)
  );

  thct_queue #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_rec(push_rec),
    .push_idx(push_idx),
    .pop(q_pop),
    .empty(q_empty),
    .full(q_full),
    .head_rec(head_rec),
    .head_idx(head_idx)
  );

  thct_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .head_rec(head_rec),
    .head_idx(head_idx),
    .wr_en(wr_en),
    .wr_entry(wr_entry),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

endmodule

[hdl/thct_checker.sv]
`include "tcp_handshake_connection_tracker_unit_defines.svh"

module thct_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [thct_pkg::OUT_W-1:0] m_tdata
);
  import thct_pkg::*;

  `THCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `THCT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
  `THCT_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  `THCT_ASSERT_NOW(a_reply_kind, m_tvalid,
    m_tdata[8] == (m_tdata[1:0] == OUT_SYNACK || m_tdata[1:0] == OUT_ESTAB))
  `THCT_ASSERT_NOW(a_full_clean, m_tvalid && m_tdata[1:0] == OUT_FULL,
    m_tdata[106:2] == '0)

endmodule

bind tcp_handshake_connection_tracker_unit thct_checker u_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import thct_pkg::*;

  localparam int CONN_SLOTS = TABLE_ENTRIES_DEF;
  localparam logic [3:0] FL_NONE = 4'b0000;
  localparam logic [3:0] FL_SYN = 4'b0001;
  localparam logic [3:0] FL_ACK = 4'b0010;
  localparam logic [3:0] FL_PSH = 4'b0100;
  localparam logic [3:0] FL_FIN = 4'b1000;
  localparam int RANDOM_SEGMENTS = 600;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    item_t seg;
    bit typed;
    result_t want;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  logic [31:0] conn_ip [CONN_SLOTS];
  logic [15:0] conn_peer_port [CONN_SLOTS];
  logic [15:0] conn_our_port [CONN_SLOTS];
  status_t conn_state [CONN_SLOTS];
  logic [31:0] conn_seq [CONN_SLOTS];
  logic [31:0] conn_ack [CONN_SLOTS];
  int conn_used = 0;

  result_t pending_results[$];
  dir_row_t dir_rows[$];
  int mismatch_count = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_req = 1'b0;

  tcp_handshake_connection_tracker_unit DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic item_t mk_seg(logic [31:0] ip, logic [15:0] pport, logic [15:0] lport,
                                   logic [31:0] rseq, logic [3:0] fl, logic [31:0] isn);
    item_t s;
    s = '0;
    s.peer_ip = ip;
    s.peer_port = pport;
    s.local_port = lport;
    s.remote_seq = rseq;
    s.flag_syn = fl[0];
    s.flag_ack = fl[1];
    s.flag_psh = fl[2];
    s.flag_fin = fl[3];
    s.fresh_isn = isn;
    return s;
  endfunction

  function automatic result_t mk_res(outcome_t oc, int slot, bit vld, bit syn, bit psh,
                                     logic [15:0] src, logic [15:0] dst,
                                     logic [31:0] seq, logic [31:0] ack);
    result_t r;
    r = '0;
    r.outcome = oc;
    r.slot = slot[SLOT_W-1:0];
    r.reply_valid = vld;
    r.reply_syn = syn;
    r.reply_psh = psh;
    r.reply_src_port = src;
    r.reply_dst_port = dst;
    r.reply_seq = seq;
    r.reply_ack_seq = ack;
    return r;
  endfunction

  function automatic result_t predict_segment(item_t s);
    result_t r;
    int idx;
    bit bare_syn;
    bit bare_ack;
    r = '0;
    idx = -1;
    bare_syn = s.flag_syn && !s.flag_ack && !s.flag_psh && !s.flag_fin;
    bare_ack = !s.flag_syn && s.flag_ack && !s.flag_psh && !s.flag_fin;
    for (int i = 0; i < CONN_SLOTS; i++) begin
      if (idx < 0 && conn_state[i] != ST_NONE && conn_ip[i] == s.peer_ip &&
          (conn_peer_port[i] == s.peer_port || conn_our_port[i] == s.peer_port))
        idx = i;
    end
    if (idx < 0) begin
      for (int i = 0; i < CONN_SLOTS; i++) begin
        if (idx < 0 && conn_state[i] == ST_NONE && conn_ip[i] == '0 &&
            conn_peer_port[i] == '0)
          idx = i;
      end
      if (idx < 0) begin
        r.outcome = OUT_FULL;
        return r;
      end
      conn_ip[idx] = s.peer_ip;
      conn_peer_port[idx] = s.peer_port;
      conn_state[idx] = ST_CREATED;
      conn_seq[idx] = s.remote_seq;
      conn_used++;
    end
    r.slot = idx[SLOT_W-1:0];
    if (conn_state[idx] == ST_CREATED && bare_syn) begin
      conn_seq[idx] = s.fresh_isn;
      conn_ack[idx] = s.remote_seq + 32'd1;
      conn_our_port[idx] = s.local_port;
      r.outcome = OUT_SYNACK;
      r.reply_valid = 1'b1;
      r.reply_syn = 1'b1;
      r.reply_src_port = s.local_port;
      r.reply_dst_port = s.peer_port;
      r.reply_seq = conn_seq[idx];
      r.reply_ack_seq = conn_ack[idx];
    end else if (conn_state[idx] == ST_CREATED && bare_ack) begin
      conn_state[idx] = ST_ESTABLISHED;
      conn_seq[idx] = conn_seq[idx] + 32'd1;
      r.outcome = OUT_ESTAB;
      r.reply_valid = 1'b1;
      r.reply_psh = 1'b1;
      r.reply_src_port = conn_our_port[idx];
      r.reply_dst_port = conn_peer_port[idx];
      r.reply_seq = conn_seq[idx];
      r.reply_ack_seq = conn_ack[idx];
    end else begin
      r.outcome = OUT_UNEXPECTED;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic add_row(item_t s, bit typed, result_t want);
    dir_row_t row;
    row.seg = s;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic drive_segment(item_t s, bit typed, result_t want);
    result_t predicted;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= s;
    do @(posedge clk); while (!s_tready);
    predicted = predict_segment(s);
    pending_results.push_back(typed ? want : predicted);
  endtask

  initial begin : result_sink
    result_t got;
    result_t want;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing pending, got %h", $time, got);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("outcome", 32'(want.outcome), 32'(got.outcome));
          check_field("slot", 32'(want.slot), 32'(got.slot));
          check_field("reply_valid", 32'(want.reply_valid), 32'(got.reply_valid));
          check_field("reply_syn", 32'(want.reply_syn), 32'(got.reply_syn));
          check_field("reply_psh", 32'(want.reply_psh), 32'(got.reply_psh));
          check_field("reply_src_port", 32'(want.reply_src_port), 32'(got.reply_src_port));
          check_field("reply_dst_port", 32'(want.reply_dst_port), 32'(got.reply_dst_port));
          check_field("reply_seq", want.reply_seq, got.reply_seq);
          check_field("reply_ack_seq", want.reply_ack_seq, got.reply_ack_seq);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    item_t seg;
    result_t none;
    int pick;
    int j;
    int fsel;
    logic [3:0] fl;
    none = '0;
    for (int i = 0; i < CONN_SLOTS; i++) begin
      conn_ip[i] = '0;
      conn_peer_port[i] = '0;
      conn_our_port[i] = '0;
      conn_state[i] = ST_NONE;
      conn_seq[i] = '0;
      conn_ack[i] = '0;
    end

    add_row(mk_seg(32'h0a000001, 16'h1234, 16'h0050, 32'hffffffff, FL_SYN, 32'h11111111), 1,
            mk_res(OUT_SYNACK, 0, 1, 1, 0, 16'h0050, 16'h1234, 32'h11111111, 32'h0));
    add_row(mk_seg(32'h0a000001, 16'h1234, 16'h0050, 32'h5, FL_ACK, 32'h0), 1,
            mk_res(OUT_ESTAB, 0, 1, 0, 1, 16'h0050, 16'h1234, 32'h11111112, 32'h0));
    add_row(mk_seg(32'h0a000001, 16'h1234, 16'h0050, 32'h6, FL_ACK, 32'h0), 1,
            mk_res(OUT_UNEXPECTED, 0, 0, 0, 0, 16'h0, 16'h0, 32'h0, 32'h0));
    add_row(mk_seg(32'hffffffff, 16'hffff, 16'hffff, 32'h0, FL_SYN, 32'hffffffff), 1,
            mk_res(OUT_SYNACK, 1, 1, 1, 0, 16'hffff, 16'hffff, 32'hffffffff, 32'h1));
    add_row(mk_seg(32'hffffffff, 16'hffff, 16'h0000, 32'h0, FL_ACK, 32'h0), 1,
            mk_res(OUT_ESTAB, 1, 1, 0, 1, 16'hffff, 16'hffff, 32'h0, 32'h1));
    add_row(mk_seg(32'h0, 16'h0, 16'h0, 32'h0, FL_NONE, 32'h0), 1,
            mk_res(OUT_UNEXPECTED, 2, 0, 0, 0, 16'h0, 16'h0, 32'h0, 32'h0));
    add_row(mk_seg(32'h0, 16'h0, 16'h8000, 32'h7fffffff, FL_SYN, 32'h80000000), 1,
            mk_res(OUT_SYNACK, 2, 1, 1, 0, 16'h8000, 16'h0, 32'h80000000, 32'h80000000));
    add_row(mk_seg(32'h12345678, 16'h4000, 16'h0abc, 32'hdeadbeef, FL_ACK, 32'h0), 1,
            mk_res(OUT_ESTAB, 3, 1, 0, 1, 16'h0, 16'h4000, 32'hdeadbef0, 32'h0));
    add_row(mk_seg(32'h0a000002, 16'h1000, 16'h0050, 32'h1, FL_SYN | FL_ACK, 32'h5), 1,
            mk_res(OUT_UNEXPECTED, 4, 0, 0, 0, 16'h0, 16'h0, 32'h0, 32'h0));
    add_row(mk_seg(32'h0a000002, 16'h1000, 16'h0050, 32'h2, FL_SYN, 32'h2468ace0), 0, none);
    add_row(mk_seg(32'h0a000003, 16'h2000, 16'h0051, 32'h3, FL_SYN | FL_FIN, 32'h7), 1,
            mk_res(OUT_UNEXPECTED, 5, 0, 0, 0, 16'h0, 16'h0, 32'h0, 32'h0));
    add_row(mk_seg(32'h0a000001, 16'h1234, 16'h0050, 32'h9, FL_PSH | FL_ACK, 32'h0), 1,
            mk_res(OUT_UNEXPECTED, 0, 0, 0, 0, 16'h0, 16'h0, 32'h0, 32'h0));
    add_row(mk_seg(32'h0a000001, 16'h0050, 16'h0060, 32'ha, FL_SYN, 32'h1), 1,
            mk_res(OUT_UNEXPECTED, 0, 0, 0, 0, 16'h0, 16'h0, 32'h0, 32'h0));
    add_row(mk_seg(32'h0a000001, 16'h5555, 16'h0060, 32'h80000000, FL_SYN, 32'h13579bdf),
            0, none);
    add_row(mk_seg(32'hc0a80001, 16'h8001, 16'h0070, 32'h4,
                   FL_SYN | FL_ACK | FL_PSH | FL_FIN, 32'h0), 1,
            mk_res(OUT_UNEXPECTED, 7, 0, 0, 0, 16'h0, 16'h0, 32'h0, 32'h0));
    add_row(mk_seg(32'h0a000001, 16'h5555, 16'h0060, 32'hb, FL_FIN, 32'h0), 0, none);
    add_row(mk_seg(32'h0a000001, 16'h0060, 16'h0060, 32'hc, FL_ACK, 32'h0), 0, none);
    add_row(mk_seg(32'hffffffff, 16'hffff, 16'hffff, 32'h1, FL_SYN, 32'h3), 1,
            mk_res(OUT_UNEXPECTED, 1, 0, 0, 0, 16'h0, 16'h0, 32'h0, 32'h0));
    add_row(mk_seg(32'h0a0a0a0a, 16'h7fff, 16'h0080, 32'h5, FL_PSH, 32'h0), 1,
            mk_res(OUT_UNEXPECTED, 8, 0, 0, 0, 16'h0, 16'h0, 32'h0, 32'h0));
    add_row(mk_seg(32'h0a000002, 16'h1000, 16'h0050, 32'h3, FL_ACK, 32'h0), 0, none);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k])
      drive_segment(dir_rows[k].seg, dir_rows[k].typed, dir_rows[k].want);

    for (int n = 0; n < RANDOM_SEGMENTS; n++) begin
      send_idle = n < RANDOM_SEGMENTS - 120 && (n / 50) % 3 != 2 && !(n >= 150 && n < 200);
      recv_idle = n < RANDOM_SEGMENTS - 120 && (n / 40) % 3 != 1;
      if (n == 150)
        hold_req = 1'b1;
      if (n == 300) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      fsel = $urandom_range(0, 9);
      fl = fsel < 4 ? FL_SYN : fsel < 8 ? FL_ACK : 4'($urandom_range(0, 15));
      seg = mk_seg($urandom(), 16'($urandom()), 16'($urandom()), $urandom(), fl, $urandom());
      pick = $urandom_range(0, 99);
      if (conn_used > 0 && pick < 75) begin
        if ($urandom_range(0, 1) == 1)
          j = $urandom_range(conn_used > 4 ? conn_used - 4 : 0, conn_used - 1);
        else
          j = $urandom_range(0, conn_used - 1);
        seg.peer_ip = conn_ip[j];
        seg.peer_port = $urandom_range(0, 9) == 0 ? conn_our_port[j] : conn_peer_port[j];
      end
      drive_segment(seg, 1'b0, none);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
